>>> sv/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and codes for the route cache with TTL and link invalidation.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int ADDR_W = 48;
  localparam int RND_W  = 16;
  localparam int TTL_W  = 8;

  // func codes
  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_LINK   = 3'd2;
  localparam logic [2:0] FUNC_TICK   = 3'd3;
  localparam logic [2:0] FUNC_FLUSH  = 3'd4;

  // status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE   = 2'd0;
  localparam logic [1:0] CFG_DROP_MOD = 2'd1;
  localparam logic [1:0] CFG_TTL      = 2'd2;

  localparam logic [15:0]      DROP_MOD_RST = 16'd50;
  localparam logic [TTL_W-1:0] TTL_RST      = 8'd20;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_LINK,
    OP_TICK,
    OP_FLUSH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] hop_addr;
    logic              hop_last;
    logic [31:0]       metric;
    logic [ADDR_W-1:0] link_from;
    logic [ADDR_W-1:0] link_to;
    logic [RND_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] hop_out;
    logic [3:0]        hop_index;
    logic [31:0]       metric_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_item_t;

  typedef struct packed {
    logic              active;
    logic [15:0]       drop_modulus;
    logic [TTL_W-1:0]  initial_ttl;
    logic              clear;
  } cfg_t;

endpackage

>>> sv/rcl_front.sv
// ----------------------------------------------------------------------------
// rcl_front
// Input side: accepts items, decodes func into an operation, two-deep queue.
// ----------------------------------------------------------------------------
module rcl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcl_pkg::in_item_t  in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output rcl_pkg::q_item_t   q_item
);

  rcl_pkg::q_item_t slot0_r, slot1_r, new_item;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;

  always_comb begin
    new_item.item = in_data;
    case (in_data.func)
      rcl_pkg::FUNC_LOOKUP: new_item.op = rcl_pkg::OP_LOOKUP;
      rcl_pkg::FUNC_INSERT: new_item.op = rcl_pkg::OP_INSERT;
      rcl_pkg::FUNC_LINK:   new_item.op = rcl_pkg::OP_LINK;
      rcl_pkg::FUNC_TICK:   new_item.op = rcl_pkg::OP_TICK;
      rcl_pkg::FUNC_FLUSH:  new_item.op = rcl_pkg::OP_FLUSH;
      default:              new_item.op = rcl_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (q_pop) begin
      if (push && cnt_r == 2'd1) slot0_r <= new_item;
      else slot0_r <= slot1_r;
      if (push && cnt_r == 2'd2) slot1_r <= new_item;
    end else if (push) begin
      if (cnt_r == 2'd0) slot0_r <= new_item;
      else slot1_r <= new_item;
    end
  end

endmodule

>>> sv/rcl_engine.sv
// ----------------------------------------------------------------------------
// rcl_engine
// Back end: table scans, commit, aging, link eviction and result output.
// ----------------------------------------------------------------------------
module rcl_engine #(
  parameter int ENTRIES  = 32,
  parameter int MAX_HOPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rcl_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  rcl_pkg::q_item_t   q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rcl_pkg::out_item_t out_data
);

  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HW  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int LW  = $clog2(MAX_HOPS + 1);
  localparam int PCW = $clog2(MAX_HOPS + 2);
  localparam int AW  = rcl_pkg::ADDR_W;

  typedef struct packed {
    logic [AW-1:0]               src;
    logic [AW-1:0]               dst;
    logic [rcl_pkg::TTL_W-1:0]   life;
    logic [31:0]                 cost;
    logic [LW-1:0]               len;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SEV, S_LRD, S_LEV, S_FIN, S_DIV, S_DEC,
    S_HRD, S_HOUT, S_CRD, S_CWR, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  rcl_pkg::in_item_t    item_r, item_nxt;
  rcl_pkg::op_t         op_r, op_nxt;
  logic [EW-1:0]        idx_r, idx_nxt, hit_r, hit_nxt, free_r, free_nxt;
  logic                 found_r, found_nxt, free_ok_r, free_ok_nxt;
  logic [HW-1:0]        hop_r, hop_nxt;
  logic [LW-1:0]        n_r, n_nxt;
  logic [PCW-1:0]       pcnt_r, pcnt_nxt;
  logic [AW-1:0]        prev_r, prev_nxt;
  logic [15:0]          rem_r, rem_nxt, rnd_r, rnd_nxt;
  logic [3:0]           dcnt_r, dcnt_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rcl_pkg::out_item_t   out_r, out_nxt;

  meta_t                meta_mem [ENTRIES];
  meta_t                meta_q, meta_wd;
  logic                 meta_we;
  logic [AW-1:0]        route_mem [ENTRIES << HW];
  logic [AW-1:0]        route_q;
  logic                 route_we;
  logic [AW-1:0]        pend_mem [MAX_HOPS];
  logic [AW-1:0]        pend_q;
  logic                 pend_we;

  logic                 slot_free, last_idx, key_hit, hop_end;
  logic [PCW-1:0]       pcnt_inc;
  logic [16:0]          rem_sh;
  logic [EW-1:0]        tgt;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_idx  = (idx_r == EW'(ENTRIES - 1));
  assign key_hit   = (meta_q.src == item_r.src_addr) && (meta_q.dst == item_r.dst_addr);
  assign hop_end   = ((LW'(hop_r) + LW'(1)) == meta_q.len);
  assign pcnt_inc  = (q_item.op == rcl_pkg::OP_INSERT && pcnt_r <= PCW'(MAX_HOPS)) ?
                     pcnt_r + PCW'(1) : pcnt_r;
  assign rem_sh    = {rem_r, rnd_r[15]};
  assign tgt       = found_r ? hit_r : free_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    found_nxt     = found_r;
    free_ok_nxt   = free_ok_r;
    hop_nxt       = hop_r;
    n_nxt         = n_r;
    pcnt_nxt      = pcnt_r;
    prev_nxt      = prev_r;
    rem_nxt       = rem_r;
    rnd_nxt       = rnd_r;
    dcnt_nxt      = dcnt_r;
    status_nxt    = status_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    meta_we       = 1'b0;
    meta_wd       = meta_q;
    route_we      = 1'b0;
    pend_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          item_nxt    = q_item.item;
          op_nxt      = q_item.op;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          status_nxt  = rcl_pkg::ST_DONE;
          state_nxt   = S_EMIT;
          case (q_item.op)
            rcl_pkg::OP_LOOKUP: begin
              if (cfg.active) state_nxt = S_SRD;
              else status_nxt = rcl_pkg::ST_MISS;
            end
            rcl_pkg::OP_INSERT: begin
              if (!cfg.active) begin
                pcnt_nxt   = '0;
                status_nxt = rcl_pkg::ST_REJECTED;
              end else begin
                pend_we  = (pcnt_r < PCW'(MAX_HOPS));
                pcnt_nxt = pcnt_inc;
                if (q_item.item.hop_last) begin
                  pcnt_nxt = '0;
                  n_nxt    = LW'(pcnt_inc);
                  if (pcnt_inc < PCW'(2) || pcnt_inc > PCW'(MAX_HOPS))
                    status_nxt = rcl_pkg::ST_REJECTED;
                  else
                    state_nxt = S_SRD;
                end
              end
            end
            rcl_pkg::OP_LINK, rcl_pkg::OP_TICK: begin
              if (cfg.active) state_nxt = S_SRD;
            end
            rcl_pkg::OP_FLUSH: valid_nxt = '0;
            default: ;
          endcase
        end
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        state_nxt = S_SRD;
        case (op_r)
          rcl_pkg::OP_LOOKUP, rcl_pkg::OP_INSERT: begin
            if (valid_r[idx_r] && key_hit && !found_r) begin
              found_nxt = 1'b1;
              hit_nxt   = idx_r;
            end
            if (!valid_r[idx_r] && !free_ok_r) begin
              free_ok_nxt = 1'b1;
              free_nxt    = idx_r;
            end
          end
          rcl_pkg::OP_TICK: begin
            if (valid_r[idx_r]) begin
              if (meta_q.life <= rcl_pkg::TTL_W'(1)) begin
                valid_nxt[idx_r] = 1'b0;
              end else begin
                meta_we      = 1'b1;
                meta_wd.life = meta_q.life - rcl_pkg::TTL_W'(1);
              end
            end
          end
          default: begin
            if (valid_r[idx_r]) begin
              hop_nxt   = '0;
              state_nxt = S_LRD;
            end
          end
        endcase
        if (state_nxt != S_LRD) begin
          if (last_idx) begin
            if (op_r == rcl_pkg::OP_LOOKUP || op_r == rcl_pkg::OP_INSERT)
              state_nxt = S_FIN;
            else
              state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_r + EW'(1);
          end
        end
      end
      S_LRD: state_nxt = S_LEV;
      S_LEV: begin
        prev_nxt  = route_q;
        state_nxt = S_LRD;
        hop_nxt   = hop_r + HW'(1);
        if ((hop_r != '0 && prev_r == item_r.link_from && route_q == item_r.link_to)
            || hop_end) begin
          if (hop_r != '0 && prev_r == item_r.link_from && route_q == item_r.link_to)
            valid_nxt[idx_r] = 1'b0;
          if (last_idx) begin
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = idx_r + EW'(1);
            state_nxt = S_SRD;
          end
        end
      end
      S_FIN: begin
        if (op_r == rcl_pkg::OP_LOOKUP) begin
          if (!found_r) begin
            status_nxt = rcl_pkg::ST_MISS;
            state_nxt  = S_EMIT;
          end else begin
            idx_nxt   = hit_r;
            rem_nxt   = '0;
            rnd_nxt   = item_r.random_value;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end else if (!found_r && !free_ok_r) begin
          status_nxt = rcl_pkg::ST_FULL;
          state_nxt  = S_EMIT;
        end else begin
          idx_nxt   = tgt;
          hop_nxt   = '0;
          state_nxt = S_CRD;
        end
      end
      S_DIV: begin
        // restoring remainder, one bit of the draw a cycle
        if (rem_sh >= {1'b0, cfg.drop_modulus}) rem_nxt = 16'(rem_sh - {1'b0, cfg.drop_modulus});
        else rem_nxt = rem_sh[15:0];
        rnd_nxt  = {rnd_r[14:0], 1'b0};
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (meta_q.life == '0 || (cfg.drop_modulus != '0 && rem_r == '0)) begin
          valid_nxt[idx_r] = 1'b0;
          status_nxt       = rcl_pkg::ST_DROPPED;
          state_nxt        = S_EMIT;
        end else begin
          hop_nxt   = '0;
          state_nxt = S_HRD;
        end
      end
      S_HRD: state_nxt = S_HOUT;
      S_HOUT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = rcl_pkg::ST_HIT;
          out_nxt.hop_out      = route_q;
          out_nxt.hop_index    = 4'(hop_r);
          out_nxt.metric_out   = meta_q.cost;
          out_nxt.last         = hop_end;
          hop_nxt              = hop_r + HW'(1);
          state_nxt            = hop_end ? S_IDLE : S_HRD;
        end
      end
      S_CRD: state_nxt = S_CWR;
      S_CWR: begin
        route_we  = 1'b1;
        hop_nxt   = hop_r + HW'(1);
        state_nxt = S_CRD;
        if ((LW'(hop_r) + LW'(1)) == n_r) begin
          meta_we          = 1'b1;
          meta_wd.src      = item_r.src_addr;
          meta_wd.dst      = item_r.dst_addr;
          meta_wd.life     = cfg.initial_ttl;
          meta_wd.cost     = item_r.metric;
          meta_wd.len      = n_r;
          valid_nxt[idx_r] = 1'b1;
          status_nxt       = rcl_pkg::ST_DONE;
          state_nxt        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt            = '0;
          out_nxt.status     = status_r;
          out_nxt.last       = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg.clear) begin
      valid_nxt = '0;
      pcnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r    <= item_nxt;
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    hit_r     <= hit_nxt;
    free_r    <= free_nxt;
    found_r   <= found_nxt;
    free_ok_r <= free_ok_nxt;
    hop_r     <= hop_nxt;
    n_r       <= n_nxt;
    prev_r    <= prev_nxt;
    rem_r     <= rem_nxt;
    rnd_r     <= rnd_nxt;
    dcnt_r    <= dcnt_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[idx_r] <= meta_wd;
    meta_q <= meta_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (route_we) route_mem[{idx_r, hop_r}] <= pend_q;
    route_q <= route_mem[{idx_r, hop_r}];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pcnt_r[HW-1:0]] <= q_item.item.hop_addr;
    pend_q <= pend_mem[hop_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("queue popped while busy");
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCW'(MAX_HOPS + 1))
    else $error("pending count out of range");
  a_hop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOUT && !slot_free) |=> state_r == S_HOUT)
    else $error("hop result lost under stall");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !slot_free) |=> state_r == S_EMIT && $stable(status_r))
    else $error("single result lost under stall");
`endif

endmodule

>>> sv/route_cache_ttl_link_invalidate.sv
// ----------------------------------------------------------------------------
// route_cache_ttl_link_invalidate
// Route cache keyed by source/destination with per-route TTL and link eviction.
// ----------------------------------------------------------------------------
// Items enter a two-deep queue that decodes the operation; the back end works
// on one item at a time and emits results through its own output register, so
// a waiting result never blocks the queue from filling. A lookup scans the
// table through the single-port entry memory, then runs a 16-step remainder
// unit for the drop draw, then reads the route memory once per hop on a hit;
// a commit scans the table and then writes the route memory hop by hop; a tick
// scans the table; a link change walks the stored hop pairs of each valid entry
// through the route memory read port. Writing the active register empties the
// cache and discards a pending insert. Entry memories have no reset; per-entry
// valid flops are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module route_cache_ttl_link_invalidate #(
  parameter int ENTRIES  = 32,
  parameter int MAX_HOPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic                         active_r;
  logic [15:0]                  dmod_r;
  logic [rcl_pkg::TTL_W-1:0]    ttl_r;
  rcl_pkg::cfg_t                cfg;
  logic                         q_valid, q_pop;
  rcl_pkg::q_item_t             q_item;

  // config registers; any write of the active register also clears the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      dmod_r   <= rcl_pkg::DROP_MOD_RST;
      ttl_r    <= rcl_pkg::TTL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcl_pkg::CFG_ACTIVE:   active_r <= cfg_wdata[0];
        rcl_pkg::CFG_DROP_MOD: dmod_r   <= cfg_wdata;
        rcl_pkg::CFG_TTL:      ttl_r    <= cfg_wdata[rcl_pkg::TTL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.active       = active_r;
  assign cfg.drop_modulus = dmod_r;
  assign cfg.initial_ttl  = ttl_r;
  assign cfg.clear        = cfg_we && (cfg_index == rcl_pkg::CFG_ACTIVE);

  rcl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rcl_engine #(
    .ENTRIES  (ENTRIES),
    .MAX_HOPS (MAX_HOPS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> test/rcl_cache_checker.sv
// ----------------------------------------------------------------------------
// rcl_cache_checker
// Watches the item, result and register ports of the route cache, keeps a
// cycle-free copy of the cache and compares every result with its prediction.
// ----------------------------------------------------------------------------
module rcl_cache_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rcl_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rcl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 32;
  localparam int NHOP = 16;

  logic                       on;
  logic [15:0]                drop_mod;
  logic [7:0]                 life0;
  bit                         ent_used [NENT];
  logic [rcl_pkg::ADDR_W-1:0] ent_src  [NENT];
  logic [rcl_pkg::ADDR_W-1:0] ent_dst  [NENT];
  int unsigned                ent_life [NENT];
  logic [31:0]                ent_cost [NENT];
  int unsigned                ent_len  [NENT];
  logic [rcl_pkg::ADDR_W-1:0] ent_hops [NENT][NHOP];
  logic [rcl_pkg::ADDR_W-1:0] pend_hops [NHOP];
  int unsigned                pend_cnt;
  rcl_pkg::out_item_t         owed_q [$];

  function automatic void push_result(logic [2:0] st, logic [rcl_pkg::ADDR_W-1:0] hop,
                                      logic [3:0] idx, logic [31:0] cost, logic lst);
    rcl_pkg::out_item_t r;
    r.status = st; r.hop_out = hop; r.hop_index = idx; r.metric_out = cost; r.last = lst;
    owed_q.insert(owed_q.size(), r);
  endfunction

  function automatic int find_route(logic [rcl_pkg::ADDR_W-1:0] s,
                                    logic [rcl_pkg::ADDR_W-1:0] d);
    for (int i = 0; i < NENT; i++)
      if (ent_used[i] && ent_src[i] == s && ent_dst[i] == d) return i;
    return -1;
  endfunction

  function automatic bit has_link(int e, logic [rcl_pkg::ADDR_W-1:0] a,
                                  logic [rcl_pkg::ADDR_W-1:0] b);
    for (int h = 0; h + 1 < int'(ent_len[e]); h++)
      if (ent_hops[e][h] == a && ent_hops[e][h+1] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] commit_route(rcl_pkg::in_item_t it);
    int unsigned n;
    int          e;
    n = pend_cnt;
    e = -1;
    pend_cnt = 0;
    if (n < 2 || n > NHOP) return rcl_pkg::ST_REJECTED;
    e = find_route(it.src_addr, it.dst_addr);
    if (e < 0) begin
      for (int i = 0; i < NENT; i++)
        if (!ent_used[i]) begin e = i; break; end
      if (e < 0) return rcl_pkg::ST_FULL;
    end
    ent_used[e] = 1'b1;
    ent_src[e]  = it.src_addr;
    ent_dst[e]  = it.dst_addr;
    ent_life[e] = life0;
    ent_cost[e] = it.metric;
    ent_len[e]  = n;
    for (int h = 0; h < int'(n); h++) ent_hops[e][h] = pend_hops[h];
    return rcl_pkg::ST_DONE;
  endfunction

  // Works out the results of one accepted item and updates the cache copy.
  function automatic void cache_step(rcl_pkg::in_item_t it);
    int          e;
    int unsigned draw;
    case (it.func)
      rcl_pkg::FUNC_LOOKUP: begin
        e = on ? find_route(it.src_addr, it.dst_addr) : -1;
        if (e < 0) begin
          push_result(rcl_pkg::ST_MISS, '0, '0, '0, 1'b1);
          return;
        end
        draw = (drop_mod == 0) ? 1 : it.random_value % drop_mod;
        if (ent_life[e] > 0 && draw != 0) begin
          for (int h = 0; h < int'(ent_len[e]); h++)
            push_result(rcl_pkg::ST_HIT, ent_hops[e][h], h[3:0], ent_cost[e],
                        h + 1 == int'(ent_len[e]));
        end else begin
          ent_used[e] = 1'b0;
          push_result(rcl_pkg::ST_DROPPED, '0, '0, '0, 1'b1);
        end
      end
      rcl_pkg::FUNC_INSERT: begin
        if (!on) begin
          pend_cnt = 0;
          push_result(rcl_pkg::ST_REJECTED, '0, '0, '0, 1'b1);
          return;
        end
        if (pend_cnt < NHOP) pend_hops[pend_cnt] = it.hop_addr;
        if (pend_cnt <= NHOP) pend_cnt++;
        if (it.hop_last) push_result(commit_route(it), '0, '0, '0, 1'b1);
        else push_result(rcl_pkg::ST_DONE, '0, '0, '0, 1'b1);
      end
      rcl_pkg::FUNC_LINK: begin
        if (on)
          for (int i = 0; i < NENT; i++)
            if (ent_used[i] && has_link(i, it.link_from, it.link_to)) ent_used[i] = 1'b0;
        push_result(rcl_pkg::ST_DONE, '0, '0, '0, 1'b1);
      end
      rcl_pkg::FUNC_TICK: begin
        if (on)
          for (int i = 0; i < NENT; i++)
            if (ent_used[i]) begin
              if (ent_life[i] <= 1) ent_used[i] = 1'b0;
              else ent_life[i]--;
            end
        push_result(rcl_pkg::ST_DONE, '0, '0, '0, 1'b1);
      end
      rcl_pkg::FUNC_FLUSH: begin
        for (int i = 0; i < NENT; i++) ent_used[i] = 1'b0;
        push_result(rcl_pkg::ST_DONE, '0, '0, '0, 1'b1);
      end
      default: push_result(rcl_pkg::ST_DONE, '0, '0, '0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    rcl_pkg::out_item_t want;
    if (!rst_n) begin
      on = 1'b0;
      drop_mod = rcl_pkg::DROP_MOD_RST;
      life0 = rcl_pkg::TTL_RST;
      pend_cnt = 0;
      for (int i = 0; i < NENT; i++) ent_used[i] = 1'b0;
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcl_pkg::CFG_ACTIVE: begin
            on = cfg_wdata[0];
            pend_cnt = 0;
            for (int i = 0; i < NENT; i++) ent_used[i] = 1'b0;
          end
          rcl_pkg::CFG_DROP_MOD: drop_mod = cfg_wdata;
          rcl_pkg::CFG_TTL:      life0 = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cache_step(in_data);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result with nothing predicted: %p", out_data);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.hop_out !== want.hop_out) begin
            $error("hop_out: expected %h, got %h", want.hop_out, out_data.hop_out);
            fail_count++;
          end
          if (out_data.hop_index !== want.hop_index) begin
            $error("hop_index: expected %0d, got %0d", want.hop_index, out_data.hop_index);
            fail_count++;
          end
          if (out_data.metric_out !== want.metric_out) begin
            $error("metric_out: expected %h, got %h", want.metric_out, out_data.metric_out);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

>>> test/tb_route_cache_ttl_link_invalidate.sv
// ----------------------------------------------------------------------------
// tb_route_cache_ttl_link_invalidate
// Drives directed and random route traffic (inserts, lookups, link changes,
// aging, flushes) through several register settings with random idling on
// both sides; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_route_cache_ttl_link_invalidate;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst single item: a link change walks the stored hop pairs of every entry.
  localparam int SETTLE     = 1200;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rcl_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rcl_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 fail_count;
  int                 results_owed;

  // Shared knobs: calm turns idling off on both sides, want_hold asks the
  // receiver for its one long hold-off.
  bit calm      = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent = 0;

  logic [rcl_pkg::ADDR_W-1:0] src_pool [6];
  logic [rcl_pkg::ADDR_W-1:0] dst_pool [7];
  logic [rcl_pkg::ADDR_W-1:0] hop_pool [8];

  route_cache_ttl_link_invalidate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rcl_cache_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off so the input backs up.
  initial out_stall = 1'b0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 17);
    end
  end

  // Watchdog: any cycle with no handshake on either side counts.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [rcl_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[rcl_pkg::ADDR_W-1:0];
  endfunction

  // Every field random, so unused fields toggle all their bits too.
  function automatic rcl_pkg::in_item_t rand_item();
    rcl_pkg::in_item_t it;
    it.func         = 3'($urandom_range(0, 7));
    it.src_addr     = rand_addr();
    it.dst_addr     = rand_addr();
    it.hop_addr     = rand_addr();
    it.hop_last     = 1'($urandom_range(0, 1));
    it.metric       = $urandom();
    it.link_from    = rand_addr();
    it.link_to      = rand_addr();
    it.random_value = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send(rcl_pkg::in_item_t it);
    bit took;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic send_op(logic [2:0] f);
    rcl_pkg::in_item_t it;
    it = rand_item();
    it.func = f;
    send(it);
  endtask

  task automatic send_route(logic [rcl_pkg::ADDR_W-1:0] s, logic [rcl_pkg::ADDR_W-1:0] d,
                            logic [rcl_pkg::ADDR_W-1:0] hops [$], logic [31:0] cost);
    rcl_pkg::in_item_t it;
    foreach (hops[h]) begin
      it = rand_item();
      it.func     = rcl_pkg::FUNC_INSERT;
      it.src_addr = s;
      it.dst_addr = d;
      it.hop_addr = hops[h];
      it.hop_last = (h == hops.size() - 1);
      it.metric   = cost;
      send(it);
    end
  endtask

  task automatic send_lookup(logic [rcl_pkg::ADDR_W-1:0] s, logic [rcl_pkg::ADDR_W-1:0] d,
                             logic [15:0] rnd);
    rcl_pkg::in_item_t it;
    it = rand_item();
    it.func = rcl_pkg::FUNC_LOOKUP;
    it.src_addr = s;
    it.dst_addr = d;
    it.random_value = rnd;
    send(it);
  endtask

  task automatic send_link(logic [rcl_pkg::ADDR_W-1:0] a, logic [rcl_pkg::ADDR_W-1:0] b);
    rcl_pkg::in_item_t it;
    it = rand_item();
    it.func = rcl_pkg::FUNC_LINK;
    it.link_from = a;
    it.link_to = b;
    send(it);
  endtask

  // Wait until every predicted result is in, then let a long scan finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed routes over small address pools so that lookups hit,
  // links match and the table fills; the rest is noise.
  task automatic random_traffic(int count);
    int stop;
    int r;
    int n;
    logic [rcl_pkg::ADDR_W-1:0] hops [$];
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        hops.delete();
        if ($urandom_range(0, 99) < 88) n = $urandom_range(2, 16);
        else n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(17, 18);
        for (int h = 0; h < n; h++)
          hops.insert(hops.size(), ($urandom_range(0, 9) == 0) ? rand_addr()
                                   : hop_pool[$urandom_range(0, 7)]);
        send_route(src_pool[$urandom_range(0, 5)], dst_pool[$urandom_range(0, 6)],
                   hops, $urandom());
      end else if (r < 72) begin
        if ($urandom_range(0, 9) == 0) send_lookup(rand_addr(), rand_addr(),
                                                   16'($urandom_range(0, 65535)));
        else send_lookup(src_pool[$urandom_range(0, 5)], dst_pool[$urandom_range(0, 6)],
                         16'($urandom_range(0, 65535)));
      end else if (r < 80) begin
        if ($urandom_range(0, 4) == 0) send_link(rand_addr(), rand_addr());
        else send_link(hop_pool[$urandom_range(0, 7)], hop_pool[$urandom_range(0, 7)]);
      end else if (r < 88) begin
        send_op(rcl_pkg::FUNC_TICK);
      end else if (r < 90) begin
        send_op(rcl_pkg::FUNC_FLUSH);
      end else if (r < 93) begin
        send_op(3'($urandom_range(5, 7)));
      end else begin
        // stray hop that is not last: joins whatever route comes next
        rcl_pkg::in_item_t it;
        it = rand_item();
        it.func = rcl_pkg::FUNC_INSERT;
        it.hop_last = 1'b0;
        send(it);
      end
    end
  endtask

  initial begin
    logic [rcl_pkg::ADDR_W-1:0] hops [$];
    logic [rcl_pkg::ADDR_W-1:0] ones;
    ones = '1;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = rcl_pkg::CFG_ACTIVE;
    cfg_wdata = '0;
    foreach (src_pool[i]) src_pool[i] = rand_addr();
    foreach (dst_pool[i]) dst_pool[i] = rand_addr();
    foreach (hop_pool[i]) hop_pool[i] = rand_addr();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: inactive after reset, everything misses or does nothing
    send_lookup(ones, '0, 16'd1);
    hops = '{ones, '0};
    send_route(ones, '0, hops, 32'hFFFF_FFFF);   // both hops rejected
    send_link(ones, '0);
    send_op(rcl_pkg::FUNC_TICK);
    send_op(rcl_pkg::FUNC_FLUSH);
    send_op(3'd7);
    drain();

    write_reg(rcl_pkg::CFG_ACTIVE, 16'd1);
    // single-hop route is too short
    hops = '{ones};
    send_route(ones, '0, hops, 32'd5);
    // extreme addresses and metric; hit, then drop on a zero draw (50 % 50)
    hops = '{'0, ones};
    send_route(ones, '0, hops, 32'hFFFF_FFFF);
    send_lookup(ones, '0, 16'hFFFF);
    send_lookup(ones, '0, 16'd50);
    send_lookup(ones, '0, 16'd1);
    // reinsert, then a link change on that hop pair evicts it
    send_route(ones, '0, hops, 32'd0);
    send_link('0, ones);
    send_lookup(ones, '0, 16'd1);
    // replace under the same key, age it, flush
    send_route(ones, '0, hops, 32'd9);
    hops = '{ones, '0, ones};
    send_route(ones, '0, hops, 32'd10);
    send_op(rcl_pkg::FUNC_TICK);
    send_lookup(ones, '0, 16'd3);
    send_op(rcl_pkg::FUNC_FLUSH);
    drain();

    // --- random, default drop and ttl
    random_traffic(100);
    drain();

    // --- no random drop, longest life: table fills; long hold-off and a calm stretch
    write_reg(rcl_pkg::CFG_DROP_MOD, 16'd0);
    write_reg(rcl_pkg::CFG_TTL, 16'd255);
    want_hold = 1'b1;
    random_traffic(60);
    calm = 1'b1;
    random_traffic(50);
    calm = 1'b0;
    drain();

    // --- widest divisor, short life so ticks evict
    write_reg(rcl_pkg::CFG_DROP_MOD, 16'hFFFF);
    write_reg(rcl_pkg::CFG_TTL, 16'd2);
    random_traffic(80);
    drain();

    // --- zero life: each route dies on its next lookup or tick
    write_reg(rcl_pkg::CFG_ACTIVE, 16'd1);
    write_reg(rcl_pkg::CFG_DROP_MOD, 16'd7);
    write_reg(rcl_pkg::CFG_TTL, 16'd0);
    random_traffic(35);
    drain();

    // --- disabled again
    write_reg(rcl_pkg::CFG_ACTIVE, 16'd0);
    random_traffic(20);
    drain();

    if (fail_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
